// File: hdl/process_state_queue_manager_unit_defines.svh
// Assertion helpers for the queue manager checker
`ifndef PROCESS_STATE_QUEUE_MANAGER_UNIT_DEFINES_SVH
`define PROCESS_STATE_QUEUE_MANAGER_UNIT_DEFINES_SVH

// same-cycle implication
`define PSQ_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PSQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/psq_pkg.sv
package psq_pkg;

    localparam int NUM_PROCS_DEF = 16;
    localparam int PID_W         = 4;
    localparam int PRI_W         = 4;
    localparam int MAX_PRI       = 9;
    localparam int NQ            = 4;
    localparam int QLEN_W        = 5;

    typedef enum logic [3:0] {
        CMD_CREATE  = 4'd0,
        CMD_DELETE  = 4'd1,
        CMD_SUSPEND = 4'd2,
        CMD_RESUME  = 4'd3,
        CMD_BLOCK   = 4'd4,
        CMD_UNBLOCK = 4'd5,
        CMD_SETPRI  = 4'd6,
        CMD_SHOW    = 4'd7,
        CMD_READ    = 4'd8
    } cmd_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_NOTFOUND = 3'd1,
        ST_BADPRI   = 3'd2,
        ST_WRONG    = 3'd3,
        ST_FULL     = 3'd4,
        ST_BADPOS   = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        PS_READY        = 2'd0,
        PS_SUSP_READY   = 2'd1,
        PS_BLOCKED      = 2'd2,
        PS_SUSP_BLOCKED = 2'd3
    } pstate_t;

    typedef enum logic [1:0] {
        QM_IDLE   = 2'd0,
        QM_INS    = 2'd1,
        QM_REM    = 2'd2,
        QM_SETPRI = 2'd3
    } qmode_t;

    typedef enum logic [1:0] {
        PH_HOLD  = 2'd0,
        PH_CLR   = 2'd1,
        PH_SCAN  = 2'd2,
        PH_APPLY = 2'd3
    } phase_t;

    typedef enum logic [2:0] {
        FS_IDLE   = 3'd0,
        FS_DECIDE = 3'd1,
        FS_SCAN   = 3'd2,
        FS_APPLY  = 3'd3,
        FS_RDREQ  = 3'd4,
        FS_RPT    = 3'd5,
        FS_OUT    = 3'd6
    } fsm_t;

    typedef struct packed {
        logic             occ;
        logic [PID_W-1:0] id;
        logic [PRI_W-1:0] pri;
    } slot_t;

    typedef struct packed {
        phase_t           phase;
        qmode_t           mode;
        logic             sorted;
        logic [PID_W-1:0] kid;
        logic [PRI_W-1:0] kpri;
        logic [PID_W-1:0] pos;
    } cell_ctl_t;

    typedef struct packed {
        pstate_t          state;
        logic [PRI_W-1:0] pri;
        logic             cls;
    } entry_t;

endpackage

// File: hdl/psq_cell.sv
module psq_cell #(
    parameter int IDX = 0
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  psq_pkg::cell_ctl_t         ctl,
    input  psq_pkg::slot_t             left_slot,
    input  logic                       left_mark,
    input  logic [psq_pkg::PID_W-1:0]  left_carry,
    input  psq_pkg::slot_t             right_slot,
    output psq_pkg::slot_t             slot,
    output logic                       mark,
    output logic [psq_pkg::PID_W-1:0]  carry
);
    import psq_pkg::*;

    slot_t            slot_reg, slot_next;
    logic             mark_reg, mark_next;
    logic [PID_W-1:0] carry_reg, carry_next;
    logic             stop;
    logic             hit;

    always_comb
    begin
        case (ctl.mode)
            QM_INS:
            begin
                if (ctl.sorted)
                    stop = !(slot_reg.occ && (slot_reg.pri >= ctl.kpri));
                else
                    stop = !slot_reg.occ;
            end
            QM_REM:  stop = slot_reg.occ && (slot_reg.id == ctl.kid);
            default: stop = 1'b0;
        endcase
    end

    assign hit = (32'(ctl.pos) == IDX);

    always_comb
    begin
        slot_next  = slot_reg;
        mark_next  = mark_reg;
        carry_next = carry_reg;
        case (ctl.phase)
            PH_CLR:  mark_next = 1'b0;
            PH_SCAN:
            begin
                mark_next  = left_mark | stop;
                carry_next = hit ? slot_reg.id : left_carry;
            end
            PH_APPLY:
            begin
                case (ctl.mode)
                    QM_INS:
                    begin
                        if (left_mark)
                            slot_next = left_slot;
                        else if (mark_reg)
                            slot_next = '{occ: 1'b1, id: ctl.kid, pri: ctl.kpri};
                    end
                    QM_REM:
                    begin
                        if (mark_reg)
                            slot_next = right_slot;
                    end
                    QM_SETPRI:
                    begin
                        if (slot_reg.occ && (slot_reg.id == ctl.kid))
                            slot_next.pri = ctl.kpri;
                    end
                    default: slot_next = slot_reg;
                endcase
            end
            default: slot_next = slot_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg <= '0;
            mark_reg <= 1'b0;
        end
        else
        begin
            slot_reg <= slot_next;
            mark_reg <= mark_next;
        end
    end

    always_ff @(posedge clk)
    begin
        carry_reg <= carry_next;
    end

    assign slot  = slot_reg;
    assign mark  = mark_reg;
    assign carry = carry_reg;

endmodule

// File: hdl/psq_table.sv
module psq_table #(
    parameter  int NUM_PROCS = psq_pkg::NUM_PROCS_DEF,
    localparam int IDXW      = $clog2(NUM_PROCS)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [IDXW-1:0]      rd_addr,
    output psq_pkg::entry_t      rd_data,
    input  logic                 wr_en,
    input  logic [IDXW-1:0]      wr_addr,
    input  psq_pkg::entry_t      wr_data,
    input  logic                 vld_set,
    input  logic                 vld_clr,
    output logic [NUM_PROCS-1:0] valid
);
    import psq_pkg::*;

    entry_t               mem [NUM_PROCS];
    entry_t               rd_data_reg;
    logic [NUM_PROCS-1:0] valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (vld_set)
            valid_reg[wr_addr] <= 1'b1;
        else if (vld_clr)
            valid_reg[wr_addr] <= 1'b0;
    end

    assign rd_data = rd_data_reg;
    assign valid   = valid_reg;

endmodule

// File: hdl/process_state_queue_manager_unit.sv
// A successful command is decoded, scanned, applied, read back and reported;
//   a rejected one goes from decode straight to the result; one request in flight at a time.
// Throughput: next request taken the cycle after the result is taken.
// The scan runs over the four chains of NUM_PROCS cells side by side.
// Reset clears entry valid bits, queue occupancy and counts at once; no clearing pass.
module process_state_queue_manager_unit #(
    parameter int NUM_PROCS = psq_pkg::NUM_PROCS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [3:0] cmd,
    input  logic [3:0] proc_id,
    input  logic [3:0] new_priority,
    input  logic       class_type,
    input  logic [1:0] queue_sel,
    input  logic [3:0] position,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [2:0] status,
    output logic [1:0] proc_state,
    output logic [3:0] priority_out,
    output logic       class_out,
    output logic [3:0] proc_id_out,
    output logic [4:0] queue_length
);
    import psq_pkg::*;

    localparam int IDXW = $clog2(NUM_PROCS);
    localparam int CNTW = $clog2(NUM_PROCS + 1);
    localparam int SCW  = $clog2(NUM_PROCS);

    fsm_t             state_reg, state_next;
    cmd_t             cmd_reg;
    logic [PID_W-1:0] id_reg;
    logic [PRI_W-1:0] pri_reg;
    logic             cls_reg;
    logic [1:0]       qs_reg;
    logic [PID_W-1:0] pos_reg;
    qmode_t           qmode_reg [NQ];
    qmode_t           qmode_dec [NQ];
    logic [PRI_W-1:0] kpri_reg, kpri_dec;
    logic [CNTW-1:0]  cnt_reg [NQ];
    logic [SCW-1:0]   scan_reg;

    status_t          status_reg;
    pstate_t          pst_reg;
    logic [PRI_W-1:0] opri_reg;
    logic             ocls_reg;
    logic [PID_W-1:0] opid_reg;
    logic [QLEN_W-1:0] qlen_reg;

    phase_t           phase;
    logic [IDXW-1:0]  tbl_rd_addr;
    entry_t           tbl_rd_data;
    logic             tbl_wr_en;
    entry_t           tbl_wr_data;
    logic             vld_set, vld_clr;
    logic [NUM_PROCS-1:0] valid_vec;

    status_t          dec_status;
    logic [QLEN_W-1:0] dec_qlen;
    logic             known;
    pstate_t          cur, nxt;
    logic             nxt_bad;
    logic [PID_W-1:0] rid;
    logic             dec_act;

    slot_t            slot_w  [NQ][NUM_PROCS];
    logic             mark_w  [NQ][NUM_PROCS];
    logic [PID_W-1:0] carry_w [NQ][NUM_PROCS];
    logic [PID_W-1:0] last_carry [NQ];
    cell_ctl_t        ctl_w [NQ];

    psq_table #(.NUM_PROCS(NUM_PROCS)) u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_addr (tbl_rd_addr),
        .rd_data (tbl_rd_data),
        .wr_en   (tbl_wr_en),
        .wr_addr (IDXW'(id_reg)),
        .wr_data (tbl_wr_data),
        .vld_set (vld_set),
        .vld_clr (vld_clr),
        .valid   (valid_vec)
    );

    for (genvar q = 0; q < NQ; q++)
    begin : g_queue
        assign ctl_w[q] = '{phase: phase, mode: qmode_reg[q], sorted: (q < 2),
                            kid: id_reg, kpri: kpri_reg, pos: pos_reg};
        assign last_carry[q] = carry_w[q][NUM_PROCS-1];
        for (genvar i = 0; i < NUM_PROCS; i++)
        begin : g_cell
            slot_t            l_slot, r_slot;
            logic             l_mark;
            logic [PID_W-1:0] l_carry;
            if (i == 0)
            begin : g_first
                assign l_slot  = '0;
                assign l_mark  = 1'b0;
                assign l_carry = '0;
            end
            else
            begin : g_mid
                assign l_slot  = slot_w[q][i-1];
                assign l_mark  = mark_w[q][i-1];
                assign l_carry = carry_w[q][i-1];
            end
            if (i == NUM_PROCS - 1)
            begin : g_last
                assign r_slot = '0;
            end
            else
            begin : g_inner
                assign r_slot = slot_w[q][i+1];
            end
            psq_cell #(.IDX(i)) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctl        (ctl_w[q]),
                .left_slot  (l_slot),
                .left_mark  (l_mark),
                .left_carry (l_carry),
                .right_slot (r_slot),
                .slot       (slot_w[q][i]),
                .mark       (mark_w[q][i]),
                .carry      (carry_w[q][i])
            );
        end
    end

    assign rid         = (cmd_reg == CMD_READ) ? last_carry[qs_reg] : id_reg;
    assign tbl_rd_addr = (state_reg == FS_IDLE) ? IDXW'(proc_id) : IDXW'(rid);
    assign dec_act     = (state_reg == FS_DECIDE);
    assign known       = (32'(id_reg) < NUM_PROCS) && valid_vec[IDXW'(id_reg)];
    assign cur         = tbl_rd_data.state;

    always_comb
    begin
        nxt     = cur;
        nxt_bad = 1'b0;
        case (cmd_reg)
            CMD_SUSPEND:
            begin
                if (cur == PS_READY)        nxt = PS_SUSP_READY;
                else if (cur == PS_BLOCKED) nxt = PS_SUSP_BLOCKED;
                else                        nxt_bad = 1'b1;
            end
            CMD_RESUME:
            begin
                if (cur == PS_SUSP_READY)        nxt = PS_READY;
                else if (cur == PS_SUSP_BLOCKED) nxt = PS_BLOCKED;
                else                             nxt_bad = 1'b1;
            end
            CMD_BLOCK:
            begin
                if (cur == PS_READY)           nxt = PS_BLOCKED;
                else if (cur == PS_SUSP_READY) nxt = PS_SUSP_BLOCKED;
                else                           nxt_bad = 1'b1;
            end
            CMD_UNBLOCK:
            begin
                if (cur == PS_BLOCKED)           nxt = PS_READY;
                else if (cur == PS_SUSP_BLOCKED) nxt = PS_SUSP_READY;
                else                             nxt_bad = 1'b1;
            end
            default: nxt_bad = 1'b1;
        endcase
    end

    always_comb
    begin
        dec_status  = ST_OK;
        dec_qlen    = '0;
        kpri_dec    = tbl_rd_data.pri;
        tbl_wr_data = tbl_rd_data;
        tbl_wr_en   = 1'b0;
        vld_set     = 1'b0;
        vld_clr     = 1'b0;
        for (int q = 0; q < NQ; q++)
            qmode_dec[q] = QM_IDLE;
        case (cmd_reg)
            CMD_CREATE:
            begin
                if (32'(pri_reg) > MAX_PRI)
                    dec_status = ST_BADPRI;
                else if ((32'(id_reg) >= NUM_PROCS) || known)
                    dec_status = ST_FULL;
                else
                begin
                    tbl_wr_data  = '{state: PS_READY, pri: pri_reg, cls: cls_reg};
                    tbl_wr_en    = dec_act;
                    vld_set      = dec_act;
                    kpri_dec     = pri_reg;
                    qmode_dec[0] = QM_INS;
                end
            end
            CMD_DELETE:
            begin
                if (!known)
                    dec_status = ST_NOTFOUND;
                else
                begin
                    vld_clr        = dec_act;
                    qmode_dec[cur] = QM_REM;
                end
            end
            CMD_SUSPEND, CMD_RESUME, CMD_BLOCK, CMD_UNBLOCK:
            begin
                if (!known)
                    dec_status = ST_NOTFOUND;
                else if (nxt_bad)
                    dec_status = ST_WRONG;
                else
                begin
                    tbl_wr_data.state = nxt;
                    tbl_wr_en         = dec_act;
                    qmode_dec[cur]    = QM_REM;
                    qmode_dec[nxt]    = QM_INS;
                end
            end
            CMD_SETPRI:
            begin
                if (!known)
                    dec_status = ST_NOTFOUND;
                else if (32'(pri_reg) > MAX_PRI)
                    dec_status = ST_BADPRI;
                else
                begin
                    tbl_wr_data.pri = pri_reg;
                    tbl_wr_en       = dec_act;
                    kpri_dec        = pri_reg;
                    for (int q = 0; q < NQ; q++)
                        qmode_dec[q] = QM_SETPRI;
                end
            end
            CMD_SHOW:
            begin
                if (!known)
                    dec_status = ST_NOTFOUND;
            end
            CMD_READ:
            begin
                if (32'(pos_reg) >= 32'(cnt_reg[qs_reg]))
                begin
                    dec_status = ST_BADPOS;
                    dec_qlen   = QLEN_W'(cnt_reg[qs_reg]);
                end
            end
            default: dec_status = ST_WRONG;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            FS_IDLE:   if (in_valid) state_next = FS_DECIDE;
            FS_DECIDE: state_next = (dec_status != ST_OK) ? FS_OUT : FS_SCAN;
            FS_SCAN:   if (scan_reg == SCW'(NUM_PROCS - 1)) state_next = FS_APPLY;
            FS_APPLY:  state_next = FS_RDREQ;
            FS_RDREQ:  state_next = FS_RPT;
            FS_RPT:    state_next = FS_OUT;
            FS_OUT:    if (out_ready) state_next = FS_IDLE;
            default:   state_next = FS_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready  = 1'b0;
        out_valid = 1'b0;
        phase     = PH_HOLD;
        case (state_reg)
            FS_IDLE:   in_ready  = 1'b1;
            FS_DECIDE: phase     = PH_CLR;
            FS_SCAN:   phase     = PH_SCAN;
            FS_APPLY:  phase     = PH_APPLY;
            FS_OUT:    out_valid = 1'b1;
            default:   phase     = PH_HOLD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FS_IDLE;
            scan_reg  <= '0;
            for (int q = 0; q < NQ; q++)
            begin
                qmode_reg[q] <= QM_IDLE;
                cnt_reg[q]   <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                FS_DECIDE:
                begin
                    scan_reg <= '0;
                    for (int q = 0; q < NQ; q++)
                        qmode_reg[q] <= qmode_dec[q];
                end
                FS_SCAN: scan_reg <= scan_reg + SCW'(1);
                FS_APPLY:
                begin
                    for (int q = 0; q < NQ; q++)
                    begin
                        if (qmode_reg[q] == QM_INS)
                            cnt_reg[q] <= cnt_reg[q] + CNTW'(1);
                        else if (qmode_reg[q] == QM_REM)
                            cnt_reg[q] <= cnt_reg[q] - CNTW'(1);
                    end
                end
                default: scan_reg <= scan_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            cmd_reg <= cmd_t'(cmd);
            id_reg  <= proc_id;
            pri_reg <= new_priority;
            cls_reg <= class_type;
            qs_reg  <= queue_sel;
            pos_reg <= position;
        end
        if (state_reg == FS_DECIDE)
        begin
            kpri_reg <= kpri_dec;
            if (dec_status != ST_OK)
            begin
                status_reg <= dec_status;
                pst_reg    <= PS_READY;
                opri_reg   <= '0;
                ocls_reg   <= 1'b0;
                opid_reg   <= '0;
                qlen_reg   <= dec_qlen;
            end
        end
        if (state_reg == FS_RPT)
        begin
            status_reg <= ST_OK;
            pst_reg    <= tbl_rd_data.state;
            opri_reg   <= tbl_rd_data.pri;
            ocls_reg   <= tbl_rd_data.cls;
            opid_reg   <= rid;
            qlen_reg   <= QLEN_W'(cnt_reg[tbl_rd_data.state]);
        end
    end

    assign status       = status_reg;
    assign proc_state   = pst_reg;
    assign priority_out = opri_reg;
    assign class_out    = ocls_reg;
    assign proc_id_out  = opid_reg;
    assign queue_length = qlen_reg;

endmodule

// File: hdl/psq_checker.sv
`include "process_state_queue_manager_unit_defines.svh"

module psq_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [2:0] status,
    input logic [3:0] priority_out,
    input logic       class_out,
    input logic [3:0] proc_id_out
);
    import psq_pkg::*;

    `PSQ_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(status), "result dropped while stalled")
    `PSQ_ASSERT_NEXT(a_no_same_cycle, in_valid && in_ready, !out_valid, "result before request was decoded")
    `PSQ_ASSERT_NOW(a_one_in_flight, out_valid, !in_ready, "request taken while result pending")
    `PSQ_ASSERT_NOW(a_err_zero, out_valid && (status != ST_OK), (priority_out == 4'd0) && !class_out && (proc_id_out == 4'd0), "error result carries entry data")

endmodule

bind process_state_queue_manager_unit psq_checker u_psq_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .priority_out (priority_out),
    .class_out    (class_out),
    .proc_id_out  (proc_id_out)
);

// File: sim/tb.sv
`timescale 1ns / 100ps

module tb;
    import psq_pkg::*;

    localparam int NPROC = 16;

    typedef struct packed {
        logic [2:0] status;
        logic [1:0] pstate;
        logic [3:0] pri;
        logic       cls;
        logic [3:0] pid;
        logic [4:0] qlen;
    } psq_result_t;

    class psq_scoreboard;
        bit          valid_tbl [NPROC];
        logic [1:0]  state_tbl [NPROC];
        logic [3:0]  pri_tbl [NPROC];
        logic        cls_tbl [NPROC];
        logic [3:0]  qslot [4][$];
        psq_result_t pending [$];
        int          errors;

        function void clear();
            for (int i = 0; i < NPROC; i++) valid_tbl[i] = 0;
            for (int q = 0; q < 4; q++) qslot[q].delete();
            pending.delete();
            errors = 0;
        endfunction

        function void q_drop(int q, logic [3:0] id);
            for (int i = 0; i < qslot[q].size(); i++)
                if (qslot[q][i] == id)
                begin
                    qslot[q].delete(i);
                    return;
                end
        endfunction

        function void q_add(int q, logic [3:0] id);
            int p;
            p = qslot[q].size();
            if (p >= NPROC) return;
            if (q < 2)
            begin
                p = 0;
                while (p < qslot[q].size() && pri_tbl[qslot[q][p]] >= pri_tbl[id]) p++;
            end
            qslot[q].insert(p, id);
        endfunction

        function psq_result_t report(logic [3:0] id);
            psq_result_t r;
            r.status = ST_OK;
            r.pstate = state_tbl[id];
            r.pri = pri_tbl[id];
            r.cls = cls_tbl[id];
            r.pid = id;
            r.qlen = 5'(qslot[state_tbl[id]].size());
            return r;
        endfunction

        function void note_request(logic [3:0] c, logic [3:0] id, logic [3:0] npri,
                                   logic cl, logic [1:0] qs, logic [3:0] pos);
            psq_result_t r;
            int nxt, cur;
            r = '0;
            nxt = 4;
            cur = valid_tbl[id] ? state_tbl[id] : 0;
            if (c == CMD_CREATE)
            begin
                if (npri > MAX_PRI) r.status = ST_BADPRI;
                else if (valid_tbl[id]) r.status = ST_FULL;
                else
                begin
                    valid_tbl[id] = 1;
                    state_tbl[id] = PS_READY;
                    pri_tbl[id] = npri;
                    cls_tbl[id] = cl;
                    q_add(PS_READY, id);
                    r = report(id);
                end
            end
            else if (c == CMD_READ)
            begin
                if (pos >= qslot[qs].size())
                begin
                    r.status = ST_BADPOS;
                    r.qlen = 5'(qslot[qs].size());
                end
                else r = report(qslot[qs][pos]);
            end
            else if (c > CMD_READ) r.status = ST_WRONG;
            else if (!valid_tbl[id]) r.status = ST_NOTFOUND;
            else if (c == CMD_DELETE)
            begin
                q_drop(cur, id);
                valid_tbl[id] = 0;
                r = report(id);
            end
            else if (c == CMD_SETPRI)
            begin
                if (npri > MAX_PRI) r.status = ST_BADPRI;
                else
                begin
                    pri_tbl[id] = npri;
                    r = report(id);
                end
            end
            else if (c == CMD_SHOW) r = report(id);
            else
            begin
                case (c)
                    CMD_SUSPEND: nxt = cur == 0 ? 1 : cur == 2 ? 3 : 4;
                    CMD_RESUME:  nxt = cur == 1 ? 0 : cur == 3 ? 2 : 4;
                    CMD_BLOCK:   nxt = cur == 0 ? 2 : cur == 1 ? 3 : 4;
                    default:     nxt = cur == 2 ? 0 : cur == 3 ? 1 : 4;
                endcase
                if (nxt > 3) r.status = ST_WRONG;
                else
                begin
                    q_drop(cur, id);
                    state_tbl[id] = 2'(nxt);
                    q_add(nxt, id);
                    r = report(id);
                end
            end
            pending.push_back(r);
        endfunction

        function void check_result(psq_result_t got);
            psq_result_t e;
            if (pending.size() == 0)
            begin
                $error("unexpected result status=%0d", got.status);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.status !== e.status)
            begin
                $error("status exp %0d got %0d", e.status, got.status); errors++;
            end
            if (got.pstate !== e.pstate)
            begin
                $error("proc_state exp %0d got %0d", e.pstate, got.pstate); errors++;
            end
            if (got.pri !== e.pri)
            begin
                $error("priority_out exp %0d got %0d", e.pri, got.pri); errors++;
            end
            if (got.cls !== e.cls)
            begin
                $error("class_out exp %0d got %0d", e.cls, got.cls); errors++;
            end
            if (got.pid !== e.pid)
            begin
                $error("proc_id_out exp %0d got %0d", e.pid, got.pid); errors++;
            end
            if (got.qlen !== e.qlen)
            begin
                $error("queue_length exp %0d got %0d", e.qlen, got.qlen); errors++;
            end
        endfunction
    endclass

    logic       clk = 0;
    logic       rst_n = 0;
    logic       in_valid = 0;
    logic       in_ready;
    logic [3:0] cmd = '0;
    logic [3:0] proc_id = '0;
    logic [3:0] new_priority = '0;
    logic       class_type = 0;
    logic [1:0] queue_sel = '0;
    logic [3:0] position = '0;
    logic       out_valid;
    logic       out_ready = 0;
    logic [2:0] status;
    logic [1:0] proc_state;
    logic [3:0] priority_out;
    logic       class_out;
    logic [3:0] proc_id_out;
    logic [4:0] queue_length;

    psq_scoreboard sched_model = new();
    bit calm_phase;
    int accepted;

    process_state_queue_manager_unit u_top (.*);

    always
    begin
        #2 clk = 1;
        #2 clk = 0;
    end

    // idle the receiver at random, hold it off for a long stretch once
    initial
    begin
        int cnt;
        repeat (11) @(posedge clk);
        while (accepted < 300)
        begin
            out_ready <= calm_phase ? 1'b1 : ($urandom_range(99) >= 32);
            @(posedge clk);
        end
        out_ready <= 0;
        cnt = 0;
        while (cnt < 400)
        begin
            @(posedge clk);
            cnt++;
        end
        forever
        begin
            out_ready <= calm_phase ? 1'b1 : ($urandom_range(99) >= 32);
            @(posedge clk);
        end
    end

    always @(posedge clk)
        if (rst_n && out_valid && out_ready)
            sched_model.check_result({status, proc_state, priority_out, class_out,
                                      proc_id_out, queue_length});

    task automatic send_request(logic [3:0] c, logic [3:0] id, logic [3:0] npri,
                                logic cl, logic [1:0] qs, logic [3:0] pos);
        while (!calm_phase && $urandom_range(99) < 32)
        begin
            in_valid <= 0;
            @(posedge clk);
        end
        in_valid <= 1;
        cmd <= c;
        proc_id <= id;
        new_priority <= npri;
        class_type <= cl;
        queue_sel <= qs;
        position <= pos;
        do @(posedge clk); while (!in_ready);
        sched_model.note_request(c, id, npri, cl, qs, pos);
        accepted++;
    endtask

    task automatic random_request();
        int sel;
        logic [3:0] c;
        logic [3:0] npri;
        sel = $urandom_range(99);
        if (sel < 4) c = 4'($urandom_range(15, 9));
        else c = 4'($urandom_range(8, 0));
        if (c == CMD_CREATE && $urandom_range(99) < 40) c = CMD_CREATE;
        npri = ($urandom_range(99) < 10) ? 4'($urandom_range(15, 10)) :
                                           4'($urandom_range(9, 0));
        send_request(c, 4'($urandom_range(15)), npri, 1'($urandom_range(1)),
                     2'($urandom_range(3)), ($urandom_range(99) < 80) ?
                     4'($urandom_range(5)) : 4'($urandom_range(15)));
    endtask

    initial
    begin
        sched_model.clear();
        calm_phase = 0;
        accepted = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        send_request(CMD_READ, 0, 0, 0, 0, 0);
        send_request(CMD_SHOW, 4'd15, 0, 0, 0, 0);
        send_request(CMD_CREATE, 4'd3, 4'd10, 0, 0, 0);
        send_request(CMD_CREATE, 4'd0, 4'd0, 1, 0, 0);
        send_request(CMD_CREATE, 4'd15, 4'd9, 0, 0, 0);
        send_request(CMD_CREATE, 4'd7, 4'd9, 1, 0, 0);
        send_request(CMD_CREATE, 4'd7, 4'd2, 0, 0, 0);
        send_request(CMD_READ, 0, 0, 0, 2'd0, 4'd1);
        send_request(CMD_READ, 0, 0, 0, 2'd0, 4'd15);
        send_request(CMD_RESUME, 4'd7, 0, 0, 0, 0);
        send_request(CMD_UNBLOCK, 4'd7, 0, 0, 0, 0);
        send_request(CMD_SUSPEND, 4'd7, 0, 0, 0, 0);
        send_request(CMD_BLOCK, 4'd7, 0, 0, 0, 0);
        send_request(CMD_SUSPEND, 4'd7, 0, 0, 0, 0);
        send_request(CMD_RESUME, 4'd7, 0, 0, 0, 0);
        send_request(CMD_UNBLOCK, 4'd7, 0, 0, 0, 0);
        send_request(CMD_SETPRI, 4'd1, 4'd5, 0, 0, 0);
        send_request(CMD_SETPRI, 4'd0, 4'd15, 0, 0, 0);
        send_request(CMD_SETPRI, 4'd0, 4'd9, 0, 0, 0);
        send_request(CMD_BLOCK, 4'd15, 0, 0, 0, 0);
        send_request(CMD_READ, 0, 0, 0, 2'd2, 4'd0);
        send_request(4'd15, 0, 0, 0, 0, 0);
        send_request(4'd9, 0, 0, 0, 0, 0);
        send_request(CMD_DELETE, 4'd0, 0, 0, 0, 0);
        send_request(CMD_DELETE, 4'd0, 0, 0, 0, 0);
        for (int i = 0; i < 1800; i++)
        begin
            calm_phase = (i >= 1000 && i < 1200);
            random_request();
            if (i == 600)
            begin
                in_valid <= 0;
                while (sched_model.pending.size() != 0) @(posedge clk);
            end
        end
        in_valid <= 0;
        calm_phase = 0;
        while (sched_model.pending.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
        if (sched_model.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("*** FAILED ***");
        $finish;
    end
endmodule

// File: files.f
+incdir+hdl
hdl/psq_pkg.sv
hdl/psq_cell.sv
hdl/psq_table.sv
hdl/process_state_queue_manager_unit.sv
hdl/psq_checker.sv
sim/tb.sv
